@@ design/vnf_pkg.sv @@
`timescale 1ns / 1ps
package vnf_pkg;

  localparam int OCTAVES         = 4;
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = 28;
  localparam int IDX_W           = 24;
  localparam int VAL_W           = 16;
  localparam int FADE_W          = 17;
  localparam int EXT_W           = 64;
  localparam int FRAC_W          = COORD_FRAC_BITS + VAL_W;
  localparam int OCT_LAT         = 5;
  localparam int PIPE_LAT        = OCT_LAT + 2;

  localparam logic [IDX_W-1:0] HASH_KX = 24'd5704253;
  localparam logic [IDX_W-1:0] HASH_KY = 24'd3523215;
  localparam logic [29:0]      HASH_K3 = 30'd760343429;

  typedef struct packed {
    logic [IDX_W-1:0] ix;
    logic [IDX_W-1:0] iy;
    logic [VAL_W-1:0] tx;
    logic [VAL_W-1:0] ty;
  } vnf_pt_t;

endpackage

@@ design/vnf_fade.sv @@
`timescale 1ns / 1ps
module vnf_fade import vnf_pkg::*; (
  input  logic              clk,
  input  logic [VAL_W-1:0]  t,
  output logic [FADE_W-1:0] s
);

  logic [VAL_W-1:0]  t2_r;
  logic [17:0]       k_r;
  logic [FADE_W-1:0] s_r;
  logic [31:0]       sq;
  logic [33:0]       prod;

  assign sq   = 32'(t) * 32'(t);
  assign prod = 34'(t2_r) * 34'(k_r);

  always_ff @(posedge clk) begin
    t2_r <= sq[31:16];
    k_r  <= 18'd196608 - {1'b0, t, 1'b0};
    s_r  <= prod[32:16];
  end

  assign s = s_r;

endmodule

@@ design/vnf_octave.sv @@
`timescale 1ns / 1ps
module vnf_octave import vnf_pkg::*; (
  input  logic             clk,
  input  vnf_pt_t          pt,
  output logic [VAL_W-1:0] val
);

  function automatic logic [29:0] sq_term(input logic [IDX_W-1:0] h);
    logic [53:0] p;
    p = 54'(h) * 54'({6'b0, h} + HASH_K3);
    return p[53:24];
  endfunction

  function automatic logic [VAL_W-1:0] corner(input logic [IDX_W-1:0] hx,
                                              input logic [IDX_W-1:0] hy,
                                              input logic [29:0] ex,
                                              input logic [29:0] ey);
    logic [30:0] d;
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] p;
    d = 31'(ex) + 31'(ey);
    a = 32'(hx) + 32'(d);
    b = 32'(hy) + 32'(d);
    p = 64'(a) * 64'(b);
    return p[47:32];
  endfunction

  function automatic logic [VAL_W-1:0] lerp(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b,
                                            input logic [FADE_W-1:0] s);
    logic signed [16:0] diff;
    logic signed [34:0] p;
    logic [17:0]        r;
    diff = signed'({1'b0, b}) - signed'({1'b0, a});
    p    = 35'(diff) * 35'(signed'({1'b0, s}));
    r    = {2'b0, a} + 18'(p[33:16]);
    return r[VAL_W-1:0];
  endfunction

  logic [IDX_W-1:0]  hx0_r, hx1_r, hy0_r, hy1_r;
  logic [IDX_W-1:0]  hx0_b_r, hx1_b_r, hy0_b_r, hy1_b_r;
  logic [29:0]       ex0_r, ex1_r, ey0_r, ey1_r;
  logic [VAL_W-1:0]  ca_r, cb_r, cc_r, cd_r;
  logic [VAL_W-1:0]  ab_r, cdl_r, val_r;
  logic [FADE_W-1:0] sx, sy, sx_c_r, sy_c_r, sy_d_r;
  logic [IDX_W-1:0]  ix1, iy1;
  logic [47:0]       mx0, mx1, my0, my1;

  vnf_fade u_fade_x (.clk(clk), .t(pt.tx), .s(sx));
  vnf_fade u_fade_y (.clk(clk), .t(pt.ty), .s(sy));

  assign ix1 = pt.ix + 24'd1;
  assign iy1 = pt.iy + 24'd1;
  assign mx0 = 48'(pt.ix) * 48'(HASH_KX);
  assign mx1 = 48'(ix1) * 48'(HASH_KX);
  assign my0 = 48'(pt.iy) * 48'(HASH_KY);
  assign my1 = 48'(iy1) * 48'(HASH_KY);

  always_ff @(posedge clk) begin
    hx0_r   <= mx0[IDX_W-1:0];
    hx1_r   <= mx1[IDX_W-1:0];
    hy0_r   <= my0[IDX_W-1:0];
    hy1_r   <= my1[IDX_W-1:0];
    ex0_r   <= sq_term(hx0_r);
    ex1_r   <= sq_term(hx1_r);
    ey0_r   <= sq_term(hy0_r);
    ey1_r   <= sq_term(hy1_r);
    hx0_b_r <= hx0_r;
    hx1_b_r <= hx1_r;
    hy0_b_r <= hy0_r;
    hy1_b_r <= hy1_r;
    ca_r    <= corner(hx0_b_r, hy0_b_r, ex0_r, ey0_r);
    cb_r    <= corner(hx1_b_r, hy0_b_r, ex1_r, ey0_r);
    cc_r    <= corner(hx0_b_r, hy1_b_r, ex0_r, ey1_r);
    cd_r    <= corner(hx1_b_r, hy1_b_r, ex1_r, ey1_r);
    sx_c_r  <= sx;
    sy_c_r  <= sy;
    ab_r    <= lerp(ca_r, cb_r, sx_c_r);
    cdl_r   <= lerp(cc_r, cd_r, sx_c_r);
    sy_d_r  <= sy_c_r;
    val_r   <= lerp(ab_r, cdl_r, sy_d_r);
  end

  assign val = val_r;

endmodule

@@ design/value_noise_fbm_unit.sv @@
`timescale 1ns / 1ps
// Pipeline: a request passes the input register, 5 octave stages and the sum register;
// out_valid rises together with the result in the sum register.
// Throughput: one request per cycle; busy stays low, every octave lane is
// fully pipelined (hash multiplies, fade and lerps each own a stage).
// Reset: synchronous active-low rst_n clears the valid pipeline only.
// The receiver cannot stall: out_valid strobes for exactly one cycle.
module value_noise_fbm_unit import vnf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  output logic                      out_valid,
  output logic [VAL_W-1:0]          out_noise_value
);

  logic [PIPE_LAT-1:0]      vld_r;
  logic [PIPE_LAT-1:0]      vld_nxt;
  logic signed [COORD_W-1:0] x_r, y_r;
  logic [VAL_W-1:0]         oct_val [OCTAVES];
  logic [VAL_W-1:0]         sum_nxt;
  logic [VAL_W-1:0]         sum_r;

  assign busy    = 1'b0;
  assign vld_nxt = {vld_r[PIPE_LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    x_r   <= in_coord_x;
    y_r   <= in_coord_y;
    sum_r <= sum_nxt;
  end

  for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
    logic [EXT_W-1:0]  px, py;
    logic [FRAC_W-1:0] fx, fy;
    vnf_pt_t           pt;

    assign px    = {{(EXT_W-COORD_W){x_r[COORD_W-1]}}, x_r} << g;
    assign py    = {{(EXT_W-COORD_W){y_r[COORD_W-1]}}, y_r} << g;
    assign fx    = (FRAC_W'(px[COORD_FRAC_BITS-1:0]) << VAL_W) >> COORD_FRAC_BITS;
    assign fy    = (FRAC_W'(py[COORD_FRAC_BITS-1:0]) << VAL_W) >> COORD_FRAC_BITS;
    assign pt.ix = px[COORD_FRAC_BITS+IDX_W-1:COORD_FRAC_BITS];
    assign pt.iy = py[COORD_FRAC_BITS+IDX_W-1:COORD_FRAC_BITS];
    assign pt.tx = fx[VAL_W-1:0];
    assign pt.ty = fy[VAL_W-1:0];

    vnf_octave u_oct (.clk(clk), .pt(pt), .val(oct_val[g]));
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < OCTAVES; i++) begin
      sum_nxt = sum_nxt + (oct_val[i] >> (i + 1));
    end
  end

  assign out_valid       = vld_r[PIPE_LAT-1];
  assign out_noise_value = sum_r;

  a_out_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[0], PIPE_LAT - 1))
    else $error("result without request");

  a_req_gets_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##(PIPE_LAT - 1) out_valid)
    else $error("request lost");

endmodule

@@ verif/value_noise_fbm_unit_test.sv @@
`timescale 1ns / 1ps
module value_noise_fbm_unit_test;
  import vnf_pkg::*;

  localparam longint unsigned NOISE_KX  = 64'd2069301821;
  localparam longint unsigned NOISE_KY  = 64'd7653933711;
  localparam longint unsigned NOISE_K3  = 64'd760343429;
  localparam longint unsigned MASK_Q24  = 64'hFFFFFF;
  localparam int              MAX_CYCLES = 200000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic                      busy;
  logic                      out_valid;
  logic [VAL_W-1:0]          out_noise_value;

  logic [VAL_W-1:0] noise_expected[$];
  int               error_count = 0;
  int               cycle_count = 0;
  int               gap_pct = 0;

  value_noise_fbm_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_noise_value(out_noise_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint unsigned lattice_hash(logic [IDX_W-1:0] ix, logic [IDX_W-1:0] iy);
    longint unsigned hx, hy, d, h;
    hx = (longint'(ix) * NOISE_KX) & MASK_Q24;
    hy = (longint'(iy) * NOISE_KY) & MASK_Q24;
    d  = ((hx * (hx + NOISE_K3)) >> 24) + ((hy * (hy + NOISE_K3)) >> 24);
    h  = (((hx + d) * (hy + d)) >> 24) & MASK_Q24;
    return h >> 8;
  endfunction

  function automatic longint unsigned smooth_fade(longint unsigned t);
    longint unsigned t2;
    t2 = (t * t) >> 16;
    return (t2 * (3 * 65536 - 2 * t)) >> 16;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned s);
    return (a * (65536 - s) + b * s) >> 16;
  endfunction

  function automatic longint unsigned octave_noise(logic [63:0] px, logic [63:0] py);
    logic [IDX_W-1:0] ix, iy, ix1, iy1;
    longint unsigned  sx, sy, ab, cd;
    ix  = px[COORD_FRAC_BITS +: IDX_W];
    iy  = py[COORD_FRAC_BITS +: IDX_W];
    ix1 = ix + 1'b1;
    iy1 = iy + 1'b1;
    sx  = smooth_fade(longint'(px[COORD_FRAC_BITS-1:0]));
    sy  = smooth_fade(longint'(py[COORD_FRAC_BITS-1:0]));
    ab  = blend(lattice_hash(ix, iy), lattice_hash(ix1, iy), sx);
    cd  = blend(lattice_hash(ix, iy1), lattice_hash(ix1, iy1), sx);
    return blend(ab, cd, sy);
  endfunction

  function automatic logic [VAL_W-1:0] predict_noise(logic [COORD_W-1:0] cx,
                                                     logic [COORD_W-1:0] cy);
    logic [63:0]     ex, ey;
    longint unsigned sum;
    ex  = {{(64-COORD_W){cx[COORD_W-1]}}, cx};
    ey  = {{(64-COORD_W){cy[COORD_W-1]}}, cy};
    sum = 0;
    for (int i = 0; i < OCTAVES; i++)
      sum += octave_noise(ex << i, ey << i) >> (i + 1);
    return sum[VAL_W-1:0];
  endfunction

  task automatic send_point(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    start      <= 1'b1;
    in_coord_x <= cx;
    in_coord_y <= cy;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    noise_expected.push_back(predict_noise(cx, cy));
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // results are stable across the cycle; sample mid-cycle
  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (noise_expected.size() == 0) begin
        $display("%0t: unexpected noise_value: expected none, actual %h",
                 $time, out_noise_value);
        error_count++;
      end else begin
        if (out_noise_value !== noise_expected[0]) begin
          $display("%0t: noise_value mismatch: expected %h, actual %h",
                   $time, noise_expected[0], out_noise_value);
          error_count++;
        end
        void'(noise_expected.pop_front());
      end
    end
  end

  task automatic test_extremes();
    logic [COORD_W-1:0] pts[8];
    pts = '{28'h0, 28'h7FFFFFF, 28'h8000000, 28'hFFFFFFF,
            28'h000FFFF, 28'h0010000, 28'hFFF0000, 28'hAAAAAAA};
    foreach (pts[i]) send_point(pts[i], pts[7 - i]);
    send_point(28'h7FFFFFF, 28'h7FFFFFF);
    send_point(28'h8000000, 28'h8000000);
    send_point(28'h5555555, 28'hAAAAAAA);
  endtask

  task automatic test_negative_and_cell_edges();
    send_point(28'hFFFFFFF, 28'h0000001);
    send_point(28'hFFF8000, 28'hFFFC000);
    send_point(28'h7FFF000, 28'h7FF0000);
    send_point(28'h8000001, 28'h7FFFFFE);
    send_point(28'h0008000, 28'h0008000);
    send_point(28'h3FFFFFF, 28'hC000000);
    send_point(28'h0000001, 28'hFFFFFFF);
    send_point(28'h1234567, 28'hEDCBA98);
  endtask

  task automatic test_random(int count);
    logic [COORD_W-1:0] cx, cy;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 6) begin
        cx = COORD_W'($urandom);
        cy = COORD_W'($urandom);
      end else begin
        cx = COORD_W'($urandom_range(0, 2 ** 21) - 2 ** 20);
        cy = COORD_W'($urandom_range(0, 2 ** 21) - 2 ** 20);
      end
      send_point(cx, cy);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = 30;
    test_extremes();
    test_negative_and_cell_edges();
    test_random(210);
    gap_pct = 58;
    test_random(210);
    gap_pct = 0;
    test_random(210);
    start <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
